@@ sv/swfs_pkg.sv @@
`default_nettype none
package swfs_pkg;

    localparam int WIN_DEPTH  = 1024;
    localparam int ADDR_W     = $clog2(WIN_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int FRAME_W    = 23;
    localparam int HEAP_W     = 31;
    localparam int SUM_W      = FRAME_W + CNT_W;
    localparam int DEN_W      = 24;
    localparam int FPS_W      = 30;
    localparam int SPIKE_W    = 32;
    localparam int LEN_W      = 11;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 23;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 256;

    localparam int DEF_LEN_I  = (600 > WIN_DEPTH) ? WIN_DEPTH : 600;
    localparam logic [CNT_W-1:0] DEF_LEN   = CNT_W'(DEF_LEN_I);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WIN_DEPTH);

    localparam logic [FPS_W-1:0]   FPS_NUM     = 30'd1048576000;
    localparam logic [SPIKE_W-1:0] SPIKE_MAX   = '1;

    // floor(95n/100) and floor(99n/100) as n * K >> 24, K = rank * ceil(2^24/100);
    // exact for every n up to the window depth
    localparam int RANK_SHIFT = 24;
    localparam int PROD_W     = CNT_W + RANK_SHIFT;
    localparam logic [RANK_SHIFT-1:0] RANK95_K = 24'd15938435;
    localparam logic [RANK_SHIFT-1:0] RANK99_K = 24'd16609527;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_THRESHOLD = 8'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RING_RD,
        S_RING_CAP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RING_WR,
        S_INS_RD,
        S_INS_CHK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RD_STAT,
        S_CAP_STAT,
        S_OUT
    } seq_state_t;

    typedef enum logic [0:0] {
        OP_AVG,
        OP_FPS
    } div_op_t;

    typedef enum logic [1:0] {
        ST_MIN,
        ST_MAX,
        ST_P95,
        ST_P99
    } stat_op_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

@@ sv/swfs_ram.sv @@
`default_nettype none
module swfs_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ sv/swfs_div.sv @@
`default_nettype none
module swfs_div
    import swfs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_BITS = $clog2(SUM_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [DEN_W-1:0]    den_reg, den_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(SUM_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

@@ sv/sliding_window_frame_stats.sv @@
`default_nettype none
// Sliding-window frame statistics.
// Input stream (s_*): one beat per frame; s_tuser is the clear flag, s_tdata carries
// frame_ms (signed Q10 ms) and heap_mb (signed Q10 MB). A clear empties the window,
// spike count and heap values; a beat with a negative field is not recorded.
// Output stream (m_*): exactly one beat per input beat with count, min, max, mean,
// p95, p99, spikes, fps, heap and heap peak; m_tuser says whether the sample was kept.
// Config channel (cfg_*): register 0 window length (0 means 600, latched only at
// reset and clear), register 1 spike threshold. Always ready; write while idle.
// Flow: a clear or rejected beat goes straight to the output state. A kept beat walks
// the sorted store through one registered-read RAM, a read state and a check or write
// state per entry: removal scan and shift (only when the window is full), then insert,
// then two passes through the shared serial divider (mean, then fps, skipped for a zero
// frame; ranks come from a constant multiply) and four stat reads. One beat is in work
// at a time.
// s_tready is high only while the sequencer is idle; a finished result sits in the
// output register, so a stalled receiver holds m_tdata stable and the next beat may
// still be taken. Reset (aresetn low, synchronous) empties the window and restores
// default registers; store contents are never cleared, only the fill count.
module sliding_window_frame_stats
    import swfs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [23:0] frame_ms, [55:24] heap_mb
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // [0] clear_window
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [10:0] sample_count, [33:11] min_frame, [56:34] max_frame, [79:57] avg_frame,
    // [102:80] p95_frame, [125:103] p99_frame, [157:126] spikes, [187:158] fps,
    // [218:188] heap_last, [249:219] heap_peak, [255:250] zero
    output logic [M_DATA_W-1:0]        m_tdata,
    // [0] accepted
    output logic                       m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    seq_state_t state_reg, state_next;

    logic [LEN_W-1:0]   wl_reg, wl_next;
    logic [FRAME_W-1:0] thr_reg, thr_next;
    logic [CNT_W-1:0]   cap_reg, cap_next;
    logic [ADDR_W-1:0]  wp_reg, wp_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SPIKE_W-1:0] spike_reg, spike_next;
    logic [HEAP_W-1:0]  peak_reg, peak_next;
    logic [HEAP_W-1:0]  heap_reg, heap_next;

    logic [FRAME_W-1:0] f_reg, f_next;
    logic [HEAP_W-1:0]  h_reg, h_next;
    logic               acc_reg, acc_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [FRAME_W-1:0] old_reg, old_next;
    div_op_t            op_reg, op_next;
    stat_op_t           st_reg, st_next;
    logic [ADDR_W-1:0]  r95_reg, r95_next;
    logic [ADDR_W-1:0]  r99_reg, r99_next;
    logic [FRAME_W-1:0] min_reg, min_next;
    logic [FRAME_W-1:0] max_reg, max_next;
    logic [FRAME_W-1:0] avg_reg, avg_next;
    logic [FRAME_W-1:0] p95_reg, p95_next;
    logic [FRAME_W-1:0] p99_reg, p99_next;
    logic [FPS_W-1:0]   fps_reg, fps_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic               s_fire;
    logic [CNT_W-1:0]   eff_cap;
    logic [PROD_W-1:0]  prod95, prod99;
    logic [CNT_W-1:0]   rank95, rank99;
    logic [CNT_W-1:0]   last_idx;

    logic               ring_we;
    logic [FRAME_W-1:0] ring_rdata;
    logic               srt_we;
    logic [ADDR_W-1:0]  srt_waddr, srt_raddr;
    logic [FRAME_W-1:0] srt_wdata, srt_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign last_idx  = fill_reg - 1'b1;

    // percentile ranks by reciprocal multiply of the fill count
    assign prod95 = PROD_W'(fill_reg) * PROD_W'(RANK95_K);
    assign prod99 = PROD_W'(fill_reg) * PROD_W'(RANK99_K);
    assign rank95 = prod95[RANK_SHIFT +: CNT_W];
    assign rank99 = prod99[RANK_SHIFT +: CNT_W];

    // capacity taken from the length register at clear
    always_comb begin
        if (wl_reg == '0) begin
            eff_cap = DEF_LEN;
        end else if (32'(wl_reg) > 32'(WIN_DEPTH)) begin
            eff_cap = DEPTH_CNT;
        end else begin
            eff_cap = CNT_W'(wl_reg);
        end
    end

    swfs_ram #(.WIDTH(FRAME_W), .DEPTH(WIN_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (wp_reg),
        .wdata (f_reg),
        .raddr (wp_reg),
        .rdata (ring_rdata)
    );

    swfs_ram #(.WIDTH(FRAME_W), .DEPTH(WIN_DEPTH)) u_sorted (
        .aclk  (aclk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .raddr (srt_raddr),
        .rdata (srt_rdata)
    );

    swfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_tuser || s_tdata[23] || s_tdata[55]) begin
                        state_next = S_OUT;
                    end else if (fill_reg >= cap_reg) begin
                        state_next = S_RING_RD;
                    end else begin
                        state_next = S_RING_WR;
                    end
                end
            end
            S_RING_RD:  state_next = S_RING_CAP;
            S_RING_CAP: state_next = S_SCAN_RD;
            S_SCAN_RD:  state_next = (idx_reg < fill_reg) ? S_SCAN_CHK : S_RING_WR;
            S_SCAN_CHK: state_next = (srt_rdata == old_reg) ? S_SHIFT_RD : S_SCAN_RD;
            S_SHIFT_RD: state_next = (idx_reg + 1'b1 < fill_reg) ? S_SHIFT_WR : S_RING_WR;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_RING_WR:  state_next = S_INS_RD;
            S_INS_RD:   state_next = (idx_reg == '0) ? S_DIV_GO : S_INS_CHK;
            S_INS_CHK:  state_next = (srt_rdata > f_reg) ? S_INS_RD : S_DIV_GO;
            S_DIV_GO: begin
                if (op_reg == OP_FPS && f_reg == '0) begin
                    state_next = S_RD_STAT;
                end else begin
                    state_next = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (op_reg == OP_FPS) ? S_RD_STAT : S_DIV_GO;
                end
            end
            S_RD_STAT:  state_next = S_CAP_STAT;
            S_CAP_STAT: state_next = (st_reg == ST_P99) ? S_OUT : S_RD_STAT;
            S_OUT:      state_next = (!m_tvalid_reg || m_tready) ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        wl_next    = wl_reg;
        thr_next   = thr_reg;
        cap_next   = cap_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        spike_next = spike_reg;
        peak_next  = peak_reg;
        heap_next  = heap_reg;
        f_next     = f_reg;
        h_next     = h_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        old_next   = old_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        r95_next   = r95_reg;
        r99_next   = r99_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        avg_next   = avg_reg;
        p95_next   = p95_reg;
        p99_next   = p99_reg;
        fps_next   = fps_reg;

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        ring_we   = 1'b0;
        srt_we    = 1'b0;
        srt_waddr = idx_reg[ADDR_W-1:0];
        srt_wdata = f_reg;
        srt_raddr = idx_reg[ADDR_W-1:0];

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid) begin
            if (cfg_index == CFG_WINDOW_LENGTH) begin
                wl_next = cfg_data[LEN_W-1:0];
            end else if (cfg_index == CFG_SPIKE_THRESHOLD) begin
                thr_next = cfg_data[FRAME_W-1:0];
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    f_next   = s_tdata[FRAME_W-1:0];
                    h_next   = s_tdata[24 +: HEAP_W];
                    acc_next = 1'b0;
                    idx_next = '0;
                    op_next  = OP_AVG;
                    st_next  = ST_MIN;
                    if (s_tuser) begin
                        // empty everything, relatch capacity
                        wp_next    = '0;
                        fill_next  = '0;
                        sum_next   = '0;
                        spike_next = '0;
                        peak_next  = '0;
                        heap_next  = '0;
                        cap_next   = eff_cap;
                    end else if (!s_tdata[23] && !s_tdata[55]) begin
                        acc_next = 1'b1;
                    end
                end
            end
            S_RING_RD: begin
                // ring read address is the write pointer
            end
            S_RING_CAP: begin
                old_next = ring_rdata;
                sum_next = sum_reg - SUM_W'(ring_rdata);
            end
            S_SCAN_RD: begin
                srt_raddr = idx_reg[ADDR_W-1:0];
            end
            S_SCAN_CHK: begin
                if (srt_rdata != old_reg) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SHIFT_RD: begin
                srt_raddr = ADDR_W'(idx_reg + 1'b1);
                if (!(idx_reg + 1'b1 < fill_reg)) begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            S_SHIFT_WR: begin
                srt_we    = 1'b1;
                srt_waddr = idx_reg[ADDR_W-1:0];
                srt_wdata = srt_rdata;
                idx_next  = idx_reg + 1'b1;
            end
            S_RING_WR: begin
                ring_we   = 1'b1;
                wp_next   = (CNT_W'(wp_reg) + 1'b1 >= cap_reg) ? '0 : wp_reg + 1'b1;
                sum_next  = sum_reg + SUM_W'(f_reg);
                heap_next = h_reg;
                if (h_reg > peak_reg) begin
                    peak_next = h_reg;
                end
                if (thr_reg != '0 && f_reg > thr_reg && spike_reg != SPIKE_MAX) begin
                    spike_next = spike_reg + 1'b1;
                end
                idx_next = fill_reg;
            end
            S_INS_RD: begin
                srt_raddr = ADDR_W'(idx_reg - 1'b1);
                if (idx_reg == '0) begin
                    srt_we    = 1'b1;
                    srt_waddr = '0;
                    srt_wdata = f_reg;
                    fill_next = fill_reg + 1'b1;
                end
            end
            S_INS_CHK: begin
                srt_we    = 1'b1;
                srt_waddr = idx_reg[ADDR_W-1:0];
                if (srt_rdata > f_reg) begin
                    srt_wdata = srt_rdata;
                    idx_next  = idx_reg - 1'b1;
                end else begin
                    srt_wdata = f_reg;
                    fill_next = fill_reg + 1'b1;
                end
            end
            S_DIV_GO: begin
                div_req.start = 1'b1;
                unique case (op_reg)
                    OP_AVG: begin
                        div_req.dividend = sum_reg;
                        div_req.divisor  = DEN_W'(fill_reg);
                        // fill count is final here; latch the clamped ranks
                        r95_next = (rank95 > last_idx) ? last_idx[ADDR_W-1:0]
                                                       : rank95[ADDR_W-1:0];
                        r99_next = (rank99 > last_idx) ? last_idx[ADDR_W-1:0]
                                                       : rank99[ADDR_W-1:0];
                    end
                    OP_FPS: begin
                        div_req.dividend = SUM_W'(FPS_NUM);
                        div_req.divisor  = DEN_W'(f_reg);
                        if (f_reg == '0) begin
                            div_req.start = 1'b0;
                            fps_next      = FPS_NUM;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    unique case (op_reg)
                        OP_AVG: begin
                            avg_next = div_rsp.quotient[FRAME_W-1:0];
                            op_next  = OP_FPS;
                        end
                        OP_FPS: begin
                            fps_next = div_rsp.quotient[FPS_W-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_STAT: begin
                unique case (st_reg)
                    ST_MIN:  srt_raddr = '0;
                    ST_MAX:  srt_raddr = last_idx[ADDR_W-1:0];
                    ST_P95:  srt_raddr = r95_reg;
                    ST_P99:  srt_raddr = r99_reg;
                    default: srt_raddr = '0;
                endcase
            end
            S_CAP_STAT: begin
                unique case (st_reg)
                    ST_MIN: begin
                        min_next = srt_rdata;
                        st_next  = ST_MAX;
                    end
                    ST_MAX: begin
                        max_next = srt_rdata;
                        st_next  = ST_P95;
                    end
                    ST_P95: begin
                        p95_next = srt_rdata;
                        st_next  = ST_P99;
                    end
                    ST_P99: begin
                        p99_next = srt_rdata;
                    end
                    default: begin
                    end
                endcase
            end
            S_OUT: begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = acc_reg;
                    m_tdata_next  = '0;
                    m_tdata_next[10:0] = LEN_W'(fill_reg);
                    if (fill_reg != '0) begin
                        m_tdata_next[33:11]   = min_reg;
                        m_tdata_next[56:34]   = max_reg;
                        m_tdata_next[79:57]   = avg_reg;
                        m_tdata_next[102:80]  = p95_reg;
                        m_tdata_next[125:103] = p99_reg;
                        m_tdata_next[157:126] = spike_reg;
                        m_tdata_next[187:158] = fps_reg;
                        m_tdata_next[218:188] = heap_reg;
                        m_tdata_next[249:219] = peak_reg;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wl_reg       <= LEN_W'(600);
            thr_reg      <= '0;
            cap_reg      <= DEF_LEN;
            wp_reg       <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            spike_reg    <= '0;
            peak_reg     <= '0;
            heap_reg     <= '0;
            acc_reg      <= 1'b0;
            op_reg       <= OP_AVG;
            st_reg       <= ST_MIN;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wl_reg       <= wl_next;
            thr_reg      <= thr_next;
            cap_reg      <= cap_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
            spike_reg    <= spike_next;
            peak_reg     <= peak_next;
            heap_reg     <= heap_next;
            acc_reg      <= acc_next;
            op_reg       <= op_next;
            st_reg       <= st_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        f_reg       <= f_next;
        h_reg       <= h_next;
        idx_reg     <= idx_next;
        old_reg     <= old_next;
        r95_reg     <= r95_next;
        r99_reg     <= r99_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        avg_reg     <= avg_next;
        p95_reg     <= p95_next;
        p99_reg     <= p99_next;
        fps_reg     <= fps_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
`default_nettype wire
